// ===== sv/buddy_tree_allocator_defines.svh =====
// assertion macros shared by the allocator rtl
`ifndef BUDDY_TREE_ALLOCATOR_DEFINES_SVH
`define BUDDY_TREE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BTA_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("bta assertion failed");

// next-cycle implication, disabled while reset is low
`define BTA_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bta assertion failed");

`endif

// ===== sv/bta_pkg.sv =====
// constants and codes of the buddy tree allocator
`timescale 1ns / 1ps
package bta_pkg;
	localparam int MAX_LEVELS = 10;
	localparam int NODE_COUNT = (1 << MAX_LEVELS) - 1;
	localparam int NODE_W = MAX_LEVELS;
	localparam int VEC_W = MAX_LEVELS;
	localparam int LVL_W = $clog2(MAX_LEVELS + 1);
	localparam int S_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam logic [S_W-1:0] MIN_BLOCK_CAP = 5'd22;
	localparam logic [S_W-1:0] MIN_GRANULE_LOG2 = 5'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOG2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_TOO_LARGE = 2'd1;
	localparam logic [1:0] STS_NO_SPACE = 2'd2;
	localparam logic [1:0] STS_BAD_ADDR = 2'd3;
endpackage

// ===== sv/bta_channels.sv =====
// handshake channels: request, response and register write
`timescale 1ns / 1ps
interface bta_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] request_bytes;
	logic [31:0] free_address;
	modport source(output valid, operation, request_bytes, free_address, input ready);
	modport sink(input valid, operation, request_bytes, free_address, output ready);
endinterface

interface bta_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] block_address;
	logic [4:0]  block_size_log2;
	logic [9:0]  node_index;
	modport source(output valid, status, block_address, block_size_log2, node_index,
		input ready);
	modport sink(input valid, status, block_address, block_size_log2, node_index,
		output ready);
endinterface

interface bta_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bta_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                   data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/buddy_tree_allocator.sv =====
// buddy allocator over a binary tree of allocation marks held in one memory
// One request beat in, one response beat out. Each tree node keeps a word in a
// simple dual-port memory (one read, one write a cycle, read data registered):
// bit e of node n says that some node at depth e inside the subtree of n is
// allocated, so bit depth(n) is the node's own mark. After reset a clearing pass
// writes all 1023 words; no request is taken until it ends, while register
// writes are taken at any time. An allocate first rounds the size up from the
// minimum block, then makes a leftmost-fit descent one tree level at a time
// (restarting at the root after each blocked subtree, so each of the 512
// smallest blocks may have to be tried in turn down the full depth of the tree),
// then marks the node and its ancestors. A free walks up from the leaf to the
// marked node, then refreshes the ancestors from both children. One request is
// processed at a time; the next one is taken as soon as the previous response
// is parked in the output register.
`timescale 1ns / 1ps
`include "buddy_tree_allocator_defines.svh"

module buddy_tree_allocator (
	input logic clk,
	input logic arst_n,
	bta_cfg_if.sink cfg,
	bta_req_if.sink req,
	bta_rsp_if.source rsp
);
	localparam int NW = bta_pkg::NODE_W;
	localparam int VW = bta_pkg::VEC_W;
	localparam int LW = bta_pkg::LVL_W;
	localparam int SW = bta_pkg::S_W;

	// sequencer codes
	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_SIZE = 4'd2;
	localparam logic [3:0] ST_ARD  = 4'd3;
	localparam logic [3:0] ST_AEV  = 4'd4;
	localparam logic [3:0] ST_MRD  = 4'd5;
	localparam logic [3:0] ST_MWR  = 4'd6;
	localparam logic [3:0] ST_FRD  = 4'd7;
	localparam logic [3:0] ST_FEV  = 4'd8;
	localparam logic [3:0] ST_RL   = 4'd9;
	localparam logic [3:0] ST_RR   = 4'd10;
	localparam logic [3:0] ST_RP   = 4'd11;
	localparam logic [3:0] ST_RW   = 4'd12;
	localparam logic [3:0] ST_DONE = 4'd13;

	// configuration registers
	logic [31:0]   base_q;
	logic [SW-1:0] minl_q;
	logic [3:0]    lvl_q;

	// control and work registers
	logic [3:0]    state_q;
	logic [NW-1:0] clr_q;
	logic [31:0]   req_q;
	logic [SW-1:0] s_q;
	logic [LW-1:0] d_q;
	logic [LW-1:0] t_q;
	logic [NW-1:0] loc_q;
	logic [NW-1:0] node_q;
	logic [VW-1:0] lvec_q;
	logic [VW-1:0] rvec_q;
	logic [VW-1:0] rd_q;

	// result being built, and the output register
	logic [1:0]    res_sts_q;
	logic [31:0]   res_addr_q;
	logic [SW-1:0] res_slog_q;
	logic [NW-1:0] res_node_q;
	logic          ov_q;
	logic [1:0]    out_sts_q;
	logic [31:0]   out_addr_q;
	logic [SW-1:0] out_slog_q;
	logic [NW-1:0] out_node_q;

	// mark memory
	logic [VW-1:0] mark_mem [bta_pkg::NODE_COUNT];
	logic          we_c;
	logic [NW-1:0] wa_c;
	logic [VW-1:0] wd_c;
	logic [NW-1:0] ra_c;

	// effective register values after clamping
	logic [LW-1:0] lv_c;
	logic [SW-1:0] m_c;
	logic [SW-1:0] r_c;
	logic [VW:0]   lvm_wide_c;
	logic [VW-1:0] lvm_c;

	// request decode
	logic          too_large_c;
	logic [31:0]   off_c;
	logic          bad_off_c;
	logic [31:0]   leaf_wide_c;
	logic [NW-1:0] leaf_c;

	// descent evaluation
	logic [LW-1:0] span_c;
	logic [NW-1:0] step_c;
	logic [NW-1:0] limit_c;
	logic [NW-1:0] adv_blk_c;
	logic [NW-1:0] adv_one_c;
	logic [VW-1:0] bit_t_c;
	logic [VW-1:0] bit_d_c;
	logic [VW-1:0] from_t_c;
	logic [VW-1:0] from_d_c;
	logic [NW-1:0] cand_c;
	logic [NW-1:0] free_first_c;
	logic [NW-1:0] free_loc_c;
	logic [SW-1:0] free_s_c;
	logic [NW-1:0] parent_c;
	logic          load_out_c;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign load_out_c = (state_q == ST_DONE) && (!ov_q || rsp.ready);

	assign rsp.valid = ov_q;
	assign rsp.status = out_sts_q;
	assign rsp.block_address = out_addr_q;
	assign rsp.block_size_log2 = out_slog_q;
	assign rsp.node_index = out_node_q;

	// clamp levels to 1..max, min block to 1..cap
	always_comb begin
		if (lvl_q == 4'd0) begin
			lv_c = LW'(1);
		end else if (lvl_q > 4'(bta_pkg::MAX_LEVELS)) begin
			lv_c = LW'(bta_pkg::MAX_LEVELS);
		end else begin
			lv_c = LW'(lvl_q);
		end
		if (minl_q < bta_pkg::MIN_GRANULE_LOG2) begin
			m_c = bta_pkg::MIN_GRANULE_LOG2;
		end else if (minl_q > bta_pkg::MIN_BLOCK_CAP) begin
			m_c = bta_pkg::MIN_BLOCK_CAP;
		end else begin
			m_c = minl_q;
		end
	end

	assign r_c = SW'(m_c + SW'(lv_c) - SW'(1));
	assign lvm_wide_c = ((VW+1)'(1) << lv_c) - (VW+1)'(1);
	assign lvm_c = lvm_wide_c[VW-1:0];

	// request decode, used at the accepting edge
	assign too_large_c = {1'b0, req.request_bytes} > (33'd1 << r_c);
	assign off_c = req.free_address - base_q;
	assign bad_off_c = (|(off_c & ((32'd1 << m_c) - 32'd1))) || ((off_c >> r_c) != 32'd0);
	assign leaf_wide_c = off_c >> m_c;
	assign leaf_c = NW'((NW'(1) << (lv_c - LW'(1))) - NW'(1)) + leaf_wide_c[NW-1:0];

	// descent helpers
	assign span_c = d_q - t_q;
	assign step_c = NW'(1) << span_c;
	assign limit_c = NW'(1) << d_q;
	assign adv_blk_c = (loc_q & ~(step_c - NW'(1))) + step_c;
	assign adv_one_c = loc_q + NW'(1);
	assign bit_t_c = VW'(1) << t_q;
	assign bit_d_c = VW'(1) << d_q;
	assign from_t_c = ~(bit_t_c - VW'(1)) & lvm_c;
	assign from_d_c = ~(bit_d_c - VW'(1)) & lvm_c;
	assign cand_c = (limit_c - NW'(1)) + loc_q;
	assign free_first_c = (NW'(1) << t_q) - NW'(1);
	assign free_loc_c = node_q - free_first_c;
	assign free_s_c = r_c - SW'(t_q);
	assign parent_c = (node_q - NW'(1)) >> 1;

	// memory port control
	always_comb begin
		we_c = 1'b0;
		wa_c = node_q;
		wd_c = rd_q;
		ra_c = node_q;
		unique case (state_q)
			ST_CLR: begin
				we_c = 1'b1;
				wa_c = clr_q;
				wd_c = '0;
			end
			ST_MWR: begin
				// set the allocated depth bit on the node and each ancestor
				we_c = 1'b1;
				wd_c = rd_q | bit_d_c;
			end
			ST_FEV: begin
				// clear own mark of the node found on the way up
				we_c = |(rd_q & bit_t_c);
				wd_c = rd_q & ~bit_t_c;
			end
			ST_RL: begin
				ra_c = {node_q[NW-2:0], 1'b1};
			end
			ST_RR: begin
				ra_c = NW'({node_q[NW-2:0], 1'b0} + NW'(2));
			end
			ST_RW: begin
				// parent summary rebuilt from both children plus its own mark
				we_c = 1'b1;
				wd_c = lvec_q | rvec_q | (rd_q & bit_t_c);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mark_mem[wa_c] <= wd_c;
		end
		rd_q <= mark_mem[ra_c];
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			minl_q <= 5'd4;
			lvl_q <= 4'd10;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				bta_pkg::CFG_BASE: base_q <= cfg.data;
				bta_pkg::CFG_MIN_LOG2: minl_q <= cfg.data[SW-1:0];
				bta_pkg::CFG_LEVELS: lvl_q <= cfg.data[3:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(bta_pkg::NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						if (req.operation == bta_pkg::OP_ALLOC) begin
							if (too_large_c) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_SIZE;
							end
						end else if (bad_off_c) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_FRD;
						end
					end
				end
				ST_SIZE: begin
					if (!((33'd1 << s_q) < {1'b0, req_q})) begin
						state_q <= ST_ARD;
					end
				end
				ST_ARD: state_q <= ST_AEV;
				ST_AEV: begin
					if (|(rd_q & bit_t_c)) begin
						state_q <= (adv_blk_c >= limit_c) ? ST_DONE : ST_ARD;
					end else if (t_q == d_q) begin
						if ((rd_q & from_d_c) == '0) begin
							state_q <= ST_MRD;
						end else begin
							state_q <= (adv_one_c >= limit_c) ? ST_DONE : ST_ARD;
						end
					end else if ((rd_q & from_t_c) == '0) begin
						state_q <= ST_MRD;
					end else begin
						state_q <= ST_ARD;
					end
				end
				ST_MRD: state_q <= ST_MWR;
				ST_MWR: state_q <= (node_q == '0) ? ST_DONE : ST_MRD;
				ST_FRD: state_q <= ST_FEV;
				ST_FEV: begin
					if (|(rd_q & bit_t_c)) begin
						state_q <= (node_q == '0) ? ST_DONE : ST_RL;
					end else begin
						state_q <= (node_q == '0) ? ST_DONE : ST_FRD;
					end
				end
				ST_RL: state_q <= ST_RR;
				ST_RR: state_q <= ST_RP;
				ST_RP: state_q <= ST_RW;
				ST_RW: state_q <= (node_q == '0) ? ST_DONE : ST_RL;
				ST_DONE: begin
					if (load_out_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// work registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q <= req.request_bytes;
				s_q <= m_c;
				res_sts_q <= bta_pkg::STS_OK;
				res_addr_q <= '0;
				res_slog_q <= '0;
				res_node_q <= '0;
				if (req.operation == bta_pkg::OP_ALLOC) begin
					if (too_large_c) begin
						res_sts_q <= bta_pkg::STS_TOO_LARGE;
					end
				end else if (bad_off_c) begin
					res_sts_q <= bta_pkg::STS_BAD_ADDR;
				end else begin
					node_q <= leaf_c;
					t_q <= lv_c - LW'(1);
				end
			end
			ST_SIZE: begin
				// round up one power of two a cycle
				if ((33'd1 << s_q) < {1'b0, req_q}) begin
					s_q <= s_q + SW'(1);
				end else begin
					d_q <= LW'(r_c - s_q);
					loc_q <= '0;
					t_q <= '0;
					node_q <= '0;
				end
			end
			ST_AEV: begin
				if (|(rd_q & bit_t_c)) begin
					// marked ancestor: skip every candidate under it
					loc_q <= adv_blk_c;
					t_q <= '0;
					node_q <= '0;
					if (adv_blk_c >= limit_c) begin
						res_sts_q <= bta_pkg::STS_NO_SPACE;
					end
				end else if (t_q == d_q && (rd_q & from_d_c) != '0) begin
					loc_q <= adv_one_c;
					t_q <= '0;
					node_q <= '0;
					if (adv_one_c >= limit_c) begin
						res_sts_q <= bta_pkg::STS_NO_SPACE;
					end
				end else if (t_q == d_q || (rd_q & from_t_c) == '0) begin
					// whole subtree in use range is clear: take the candidate
					node_q <= cand_c;
					res_addr_q <= base_q + (32'(loc_q) << s_q);
					res_slog_q <= s_q;
					res_node_q <= cand_c;
				end else begin
					node_q <= NW'({node_q[NW-2:0], 1'b1} + NW'((loc_q >> (span_c - LW'(1))) & NW'(1)));
					t_q <= t_q + LW'(1);
				end
			end
			ST_MWR: begin
				node_q <= parent_c;
			end
			ST_FEV: begin
				if (|(rd_q & bit_t_c)) begin
					res_addr_q <= base_q + (32'(free_loc_c) << free_s_c);
					res_slog_q <= free_s_c;
					res_node_q <= node_q;
				end else if (node_q == '0) begin
					res_sts_q <= bta_pkg::STS_BAD_ADDR;
				end
				node_q <= parent_c;
				t_q <= t_q - LW'(1);
			end
			ST_RR: lvec_q <= rd_q;
			ST_RP: rvec_q <= rd_q;
			ST_RW: begin
				node_q <= parent_c;
				t_q <= t_q - LW'(1);
			end
			default: begin
			end
		endcase
	end

	// response register: a finished result waits here while the next request runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_out_c) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_c) begin
			out_sts_q <= res_sts_q;
			out_addr_q <= res_addr_q;
			out_slog_q <= res_slog_q;
			out_node_q <= res_node_q;
		end
	end

	`BTA_ASSERT_NOW(a_depth_bound, clk, arst_n, state_q == ST_AEV, t_q <= d_q)
	`BTA_ASSERT_NOW(a_no_write_past_end, clk, arst_n, we_c,
		wa_c != NW'(bta_pkg::NODE_COUNT))
	`BTA_ASSERT_NEXT(a_result_parked, clk, arst_n, load_out_c,
		ov_q && state_q == ST_IDLE)
endmodule
